FILE: sv/cone_mesh_tessellator_macros.svh
// assertion macros shared by the cone mesh tessellator modules
// expects signals named clock and reset in the including module
`ifndef CONE_MESH_TESSELLATOR_MACROS_SVH
`define CONE_MESH_TESSELLATOR_MACROS_SVH

// same-cycle implication, off during reset
`define CMT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define CMT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/cmt_pkg.sv
// types, constants and tables of the cone mesh tessellator
// no dependencies
package cmt_pkg;

   localparam int unsigned MAX_SEGS         = 4096;
   localparam int unsigned CORDIC_STEPS_DEF = 16;
   localparam int unsigned IDX_W            = 12;
   localparam int unsigned CNT_W            = 13;
   localparam int unsigned CSR_W            = 16;
   localparam int unsigned DIV_NUM_W        = 48;
   localparam int unsigned DIV_DEN_W        = 34;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [15:0] NORM_ONE    = 16'sd16384;
   localparam logic signed [16:0] POS_LIMIT   = 17'sd65535;

   typedef enum logic [1:0] {
      CSR_HEIGHT = 2'd0,
      CSR_RADIUS = 2'd1,
      CSR_COUNT  = 2'd2
   } csr_addr_type;

   // entry of the queue between front and back
   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             bad;
   } item_type;

   typedef struct packed {
      logic [1:0]         vertex_slot;
      logic signed [16:0] pos_x;
      logic signed [16:0] pos_y;
      logic [15:0]        pos_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic               bad_index;
      logic               last;
   } rsp_type;

   // arctangent of 2^-j in units of 2^-32 turn
   function automatic logic [29:0] atan_turn(input logic [4:0] j);
      logic [29:0] a;
      case (j)
         5'd0:  a = 30'd536870912;
         5'd1:  a = 30'd316933406;
         5'd2:  a = 30'd167458907;
         5'd3:  a = 30'd85004756;
         5'd4:  a = 30'd42667331;
         5'd5:  a = 30'd21354465;
         5'd6:  a = 30'd10679838;
         5'd7:  a = 30'd5340245;
         5'd8:  a = 30'd2670163;
         5'd9:  a = 30'd1335087;
         5'd10: a = 30'd667544;
         5'd11: a = 30'd333772;
         5'd12: a = 30'd166886;
         5'd13: a = 30'd83443;
         5'd14: a = 30'd41722;
         5'd15: a = 30'd20861;
         5'd16: a = 30'd10430;
         5'd17: a = 30'd5215;
         5'd18: a = 30'd2608;
         5'd19: a = 30'd1304;
         5'd20: a = 30'd652;
         5'd21: a = 30'd326;
         5'd22: a = 30'd163;
         5'd23: a = 30'd81;
         default: a = 30'd0;
      endcase
      return a;
   endfunction

endpackage

FILE: sv/cmt_fifo.sv
// small register queue with show-ahead read
// depends on cone_mesh_tessellator_macros.svh
`include "cone_mesh_tessellator_macros.svh"
module cmt_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == (AW+1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   `CMT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_ff <= (AW+1)'(DEPTH), "queue count above depth")
   `CMT_ASSERT_NXT(a_cnt_up, do_push && !do_pop, cnt_ff == $past(cnt_ff) + 1'b1, "count missed push")

endmodule

FILE: sv/cmt_front.sv
// front part: accepts segment indexes, flags out-of-range ones, queues them
// depends on cmt_pkg and cmt_fifo
module cmt_front import cmt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [IDX_W-1:0] segment_index,
   input  logic [CNT_W-1:0] seg_count_eff,
   input  logic             q_pop,
   output logic             q_empty,
   output item_type         q_item
);
   item_type item;

   always_comb begin
      item.idx = segment_index;
      item.bad = ({1'b0, segment_index} >= seg_count_eff);
   end

   cmt_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (2)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (item),
      .full  (full),
      .pop   (q_pop),
      .rdata (q_item),
      .empty (q_empty)
   );

endmodule

FILE: sv/cmt_div.sv
// iterative restoring divider, one quotient bit per cycle
// no dependencies
module cmt_div #(
   parameter int unsigned NUM_W = 48,
   parameter int unsigned DEN_W = 34
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);
   localparam int unsigned CW = $clog2(NUM_W);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   rem_sh;
   logic             ge;

   assign done = done_ff;
   assign quo  = num_ff;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      ge      = (rem_sh >= {1'b0, den_ff});
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         rem_in = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
         num_in = {num_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NUM_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

endmodule

FILE: sv/cmt_back.sv
// back part: sequencer that builds the three vertices of one side triangle, or one bad_index result
// depends on cmt_pkg, cmt_div and cone_mesh_tessellator_macros.svh
`include "cone_mesh_tessellator_macros.svh"
module cmt_back import cmt_pkg::*; #(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      cone_height,
   input  logic [15:0]      base_radius,
   input  logic [CNT_W-1:0] seg_count_eff,
   input  logic             q_empty,
   input  item_type         q_item,
   output logic             q_pop,
   input  logic             out_full,
   output logic             out_push,
   output rsp_type          out_data
);
   localparam int unsigned SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam logic [SW-1:0] J_LAST = SW'(CORDIC_STEPS-1);

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b000000000001,
      ST_HEAD  = 12'b000000000010,
      ST_SQRT  = 12'b000000000100,
      ST_PHGO  = 12'b000000001000,
      ST_PHASE = 12'b000000010000,
      ST_ROT   = 12'b000000100000,
      ST_MUL   = 12'b000001000000,
      ST_POS   = 12'b000010000000,
      ST_NX    = 12'b000100000000,
      ST_NY    = 12'b001000000000,
      ST_NZ    = 12'b010000000000,
      ST_EMIT  = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             bad_ff, bad_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             slot2_ff, slot2_in;
   logic [63:0]      sq_n_ff, sq_n_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic [4:0]       sq_cnt_ff, sq_cnt_in;
   logic [31:0]      l_ff, l_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [31:0] z_ff, z_in;
   logic [1:0]       quad_ff, quad_in;
   logic [SW-1:0]    j_ff, j_in;
   logic signed [50:0] pcx_ff, pcx_in, pcy_ff, pcy_in, hcx_ff, hcx_in, hcy_ff, hcy_in;
   logic signed [16:0] px_ff, px_in, py_ff, py_in;
   logic signed [15:0] nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;

   logic                 div_start, div_done;
   logic [DIV_NUM_W-1:0] div_num, div_quo;
   logic [DIV_DEN_W-1:0] div_den;

   logic [63:0]        sq_trial;
   logic [32:0]        hr_sum;
   logic signed [33:0] xs, ys, c_val, s_val;
   logic signed [31:0] at;
   logic signed [16:0] h_s, r_s;
   logic [50:0]        mag_x, mag_y;
   logic [DIV_DEN_W-1:0] den2l;

   function automatic logic signed [16:0] sat_pos(input logic signed [50:0] p);
      logic signed [50:0] t;
      t = (p + (51'sd1 <<< 29)) >>> 30;
      if (t > 51'sd65535) return POS_LIMIT;
      if (t < -51'sd65535) return -POS_LIMIT;
      return t[16:0];
   endfunction

   function automatic logic signed [15:0] sat_norm(input logic [DIV_NUM_W-1:0] q,
                                                   input logic neg);
      logic [15:0] m;
      m = (q > DIV_NUM_W'(16384)) ? 16'd16384 : q[15:0];
      return neg ? -$signed(m) : $signed(m);
   endfunction

   cmt_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      h_s      = $signed({1'b0, cone_height});
      r_s      = $signed({1'b0, base_radius});
      sq_trial = sq_r_ff + sq_bit_ff;
      hr_sum   = 33'(32'(cone_height) * 32'(cone_height))
               + 33'(32'(base_radius) * 32'(base_radius));
      xs       = x_ff >>> j_ff;
      ys       = y_ff >>> j_ff;
      at       = $signed({2'b00, atan_turn(5'(j_ff))});
      mag_x    = hcx_ff[50] ? 51'(-hcx_ff) : 51'(hcx_ff);
      mag_y    = hcy_ff[50] ? 51'(-hcy_ff) : 51'(hcy_ff);
      den2l    = {1'b0, l_ff, 1'b0};
      unique case (quad_ff)
         2'd0: begin c_val = x_ff;  s_val = y_ff;  end
         2'd1: begin c_val = -y_ff; s_val = x_ff;  end
         2'd2: begin c_val = -x_ff; s_val = -y_ff; end
         2'd3: begin c_val = y_ff;  s_val = -x_ff; end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      bad_in    = bad_ff;
      k_in      = k_ff;
      slot2_in  = slot2_ff;
      sq_n_in   = sq_n_ff;
      sq_r_in   = sq_r_ff;
      sq_bit_in = sq_bit_ff;
      sq_cnt_in = sq_cnt_ff;
      l_in      = l_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      quad_in   = quad_ff;
      j_in      = j_ff;
      pcx_in    = pcx_ff;
      pcy_in    = pcy_ff;
      hcx_in    = hcx_ff;
      hcy_in    = hcy_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      nx_in     = nx_ff;
      ny_in     = ny_ff;
      nz_in     = nz_ff;
      q_pop     = 1'b0;
      out_push  = 1'b0;
      out_data  = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = den2l;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               idx_in   = q_item.idx;
               bad_in   = q_item.bad;
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (bad_ff) begin
               out_data.bad_index = 1'b1;
               out_data.last      = 1'b1;
            end else begin
               out_data.pos_z  = cone_height;
               out_data.norm_z = NORM_ONE;
            end
            if (!out_full) begin
               out_push  = 1'b1;
               k_in      = {1'b0, idx_ff};
               slot2_in  = 1'b0;
               sq_n_in   = 64'({hr_sum, 30'd0});
               sq_r_in   = '0;
               sq_bit_in = 64'd1 << 62;
               sq_cnt_in = '0;
               state_in  = bad_ff ? ST_IDLE : ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_n_ff >= sq_trial) begin
               sq_n_in = sq_n_ff - sq_trial;
               sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            sq_cnt_in = sq_cnt_ff + 1'b1;
            if (sq_cnt_ff == 5'd31) begin
               state_in = ST_PHGO;
            end
         end
         ST_PHGO: begin
            // root of the normal length is final once the loop ends
            l_in      = sq_r_ff[31:0];
            div_start = 1'b1;
            div_num   = DIV_NUM_W'({k_ff, 32'd0}) + DIV_NUM_W'(seg_count_eff >> 1);
            div_den   = DIV_DEN_W'(seg_count_eff);
            state_in  = ST_PHASE;
         end
         ST_PHASE: begin
            if (div_done) begin
               x_in     = CORDIC_GAIN;
               y_in     = '0;
               z_in     = $signed({2'b00, div_quo[29:0]});
               quad_in  = div_quo[31:30];
               j_in     = '0;
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            if (!z_ff[31]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end
            j_in = j_ff + 1'b1;
            if (j_ff == J_LAST) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            pcx_in   = r_s * c_val;
            pcy_in   = r_s * s_val;
            hcx_in   = h_s * c_val;
            hcy_in   = h_s * s_val;
            state_in = ST_POS;
         end
         ST_POS: begin
            px_in = sat_pos(pcx_ff);
            py_in = sat_pos(pcy_ff);
            if (l_ff == '0) begin
               // degenerate cone of zero height and zero radius: normal straight up
               nx_in    = '0;
               ny_in    = '0;
               nz_in    = NORM_ONE;
               state_in = ST_EMIT;
            end else begin
               div_start = 1'b1;
               div_num   = mag_x[DIV_NUM_W-1:0] + DIV_NUM_W'(l_ff);
               state_in  = ST_NX;
            end
         end
         ST_NX: begin
            if (div_done) begin
               nx_in     = sat_norm(div_quo, hcx_ff[50]);
               div_start = 1'b1;
               div_num   = mag_y[DIV_NUM_W-1:0] + DIV_NUM_W'(l_ff);
               state_in  = ST_NY;
            end
         end
         ST_NY: begin
            if (div_done) begin
               ny_in     = sat_norm(div_quo, hcy_ff[50]);
               div_start = 1'b1;
               div_num   = DIV_NUM_W'({base_radius, 30'd0}) + DIV_NUM_W'(l_ff);
               state_in  = ST_NZ;
            end
         end
         ST_NZ: begin
            if (div_done) begin
               nz_in    = sat_norm(div_quo, 1'b0);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            out_data.vertex_slot = slot2_ff ? 2'd2 : 2'd1;
            out_data.pos_x       = px_ff;
            out_data.pos_y       = py_ff;
            out_data.norm_x      = nx_ff;
            out_data.norm_y      = ny_ff;
            out_data.norm_z      = nz_ff;
            out_data.last        = slot2_ff;
            if (!out_full) begin
               out_push = 1'b1;
               if (slot2_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  slot2_in = 1'b1;
                  k_in     = k_ff + 1'b1;
                  state_in = ST_PHGO;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      bad_ff    <= bad_in;
      k_ff      <= k_in;
      slot2_ff  <= slot2_in;
      sq_n_ff   <= sq_n_in;
      sq_r_ff   <= sq_r_in;
      sq_bit_ff <= sq_bit_in;
      sq_cnt_ff <= sq_cnt_in;
      l_ff      <= l_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      quad_ff   <= quad_in;
      j_ff      <= j_in;
      pcx_ff    <= pcx_in;
      pcy_ff    <= pcy_in;
      hcx_ff    <= hcx_in;
      hcy_ff    <= hcy_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      nz_ff     <= nz_in;
   end

   `CMT_ASSERT_IMP(a_push_state, out_push, state_ff == ST_HEAD || state_ff == ST_EMIT, "result pushed outside head or emit")
   `CMT_ASSERT_IMP(a_pop_idle, q_pop, state_ff == ST_IDLE && !q_empty, "queue popped while busy")
   `CMT_ASSERT_IMP(a_div_wait, div_done, state_ff == ST_PHASE || state_ff == ST_NX || state_ff == ST_NY || state_ff == ST_NZ, "divider finished unexpectedly")

endmodule

FILE: sv/cone_mesh_tessellator.sv
// Cone side-mesh tessellator. Each transaction on the request side carries a segment index
// and yields three result transactions (apex, current rim point, next rim point), or a single
// one flagged bad_index when the index is not below the segment count. Requests are queued
// (two entries) so new ones are taken while earlier ones are still being worked on; results
// leave through a four-entry queue. The back-end sequencer uses the shared bit-per-cycle
// divider for the phase angle and the three normal components of each rim point, and an
// iterative square root for the normal length. Configuration registers are read live and
// must only be written while no transaction is in flight.
// Top level; depends on cmt_pkg, cmt_front, cmt_back and cmt_fifo.
module cone_mesh_tessellator import cmt_pkg::*; #(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [IDX_W-1:0]   req_segment_index,
   output logic               empty,
   input  logic               pop,
   output logic [1:0]         rsp_vertex_slot,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic [15:0]        rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic               rsp_bad_index,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);
   logic [15:0]      height_ff, radius_ff;
   logic [CNT_W-1:0] count_ff, count_eff;
   logic             q_pop, q_empty, out_push, out_full;
   item_type         q_item;
   rsp_type          out_data, rsp;

   assign count_eff = (count_ff < CNT_W'(MAX_SEGS)) ? count_ff : CNT_W'(MAX_SEGS);

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= 16'd256;
         radius_ff <= 16'd256;
         count_ff  <= 13'd16;
      end else if (csr_wr_en) begin
         case (csr_addr_type'(csr_index))
            CSR_HEIGHT: height_ff <= csr_wdata;
            CSR_RADIUS: radius_ff <= csr_wdata;
            CSR_COUNT:  count_ff  <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   cmt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .segment_index (req_segment_index),
      .seg_count_eff (count_eff),
      .q_pop         (q_pop),
      .q_empty       (q_empty),
      .q_item        (q_item)
   );

   cmt_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cone_height   (height_ff),
      .base_radius   (radius_ff),
      .seg_count_eff (count_eff),
      .q_empty       (q_empty),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .out_full      (out_full),
      .out_push      (out_push),
      .out_data      (out_data)
   );

   cmt_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (4)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_data),
      .full  (out_full),
      .pop   (pop),
      .rdata (rsp),
      .empty (empty)
   );

   assign rsp_vertex_slot = rsp.vertex_slot;
   assign rsp_pos_x       = rsp.pos_x;
   assign rsp_pos_y       = rsp.pos_y;
   assign rsp_pos_z       = rsp.pos_z;
   assign rsp_norm_x      = rsp.norm_x;
   assign rsp_norm_y      = rsp.norm_y;
   assign rsp_norm_z      = rsp.norm_z;
   assign rsp_bad_index   = rsp.bad_index;
   assign rsp_last        = rsp.last;

endmodule
